@@ src/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ntm_pkg.sv @@
package ntm_pkg;

	localparam int DEFAULT_DEPTH = 64;
	localparam int STAMP_W = 48;
	localparam int TAG_W = 16;
	localparam int OBJ_W = 16;
	localparam int STATUS_W = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MATCHED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic opcode;
		logic [STAMP_W-1:0] stamp;
		logic [TAG_W-1:0] frame_tag;
		logic [OBJ_W-1:0] object_total;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STAMP_W-1:0] match_stamp;
		logic [TAG_W-1:0] match_tag;
		logic [OBJ_W-1:0] match_objects;
		logic [STAMP_W-1:0] time_error;
	} rsp_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [TAG_W-1:0] tag;
		logic [OBJ_W-1:0] objects;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_RESP
	} state_t;

endpackage

@@ src/ntm_table_ram.sv @@
module ntm_table_ram #(
	parameter int DEPTH = ntm_pkg::DEFAULT_DEPTH,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input ntm_pkg::entry_t wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output ntm_pkg::entry_t rd_data
);

	ntm_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/ntm_ctrl.sv @@
`include "assert_macros.svh"

module ntm_ctrl #(
	parameter int DEPTH = ntm_pkg::DEFAULT_DEPTH,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input ntm_pkg::req_t req,
	output logic res_valid,
	input logic res_ready,
	output ntm_pkg::rsp_t res,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output ntm_pkg::entry_t wr_data,
	output logic rd_en,
	output logic [AW-1:0] rd_addr,
	input ntm_pkg::entry_t rd_data
);

	ntm_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d;
	logic carrying_q, carrying_d;
	logic op_q, op_d;
	logic [ntm_pkg::STAMP_W-1:0] key_q, key_d;
	logic [ntm_pkg::TAG_W-1:0] tag_q, tag_d;
	logic [ntm_pkg::OBJ_W-1:0] obj_q, obj_d;
	ntm_pkg::entry_t carry_q, carry_d;
	ntm_pkg::entry_t prev_q, prev_d;
	ntm_pkg::rsp_t res_q, res_d;

	ntm_pkg::entry_t new_entry;
	logic is_last, full;
	logic [ntm_pkg::STAMP_W-1:0] d_next, d_prev, d_tail;

	assign new_entry = '{stamp: key_q, tag: tag_q, objects: obj_q};
	assign is_last = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign full = cnt_q == CW'(DEPTH);
	assign d_next = rd_data.stamp - key_q;
	assign d_prev = key_q - prev_q.stamp;
	assign d_tail = key_q - rd_data.stamp;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntm_pkg::S_IDLE;
			cnt_q <= '0;
			carrying_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			carrying_q <= carrying_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		op_q <= op_d;
		key_q <= key_d;
		tag_q <= tag_d;
		obj_q <= obj_d;
		carry_q <= carry_d;
		prev_q <= prev_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		carrying_d = carrying_q;
		op_d = op_q;
		key_d = key_q;
		tag_d = tag_q;
		obj_d = obj_q;
		carry_d = carry_q;
		prev_d = prev_q;
		res_d = res_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = new_entry;
		rd_en = 1'b0;
		rd_addr = idx_q + AW'(1);

		unique case (state_q)
			ntm_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op_d = req.opcode;
					key_d = req.stamp;
					tag_d = req.frame_tag;
					obj_d = req.object_total;
					carrying_d = 1'b0;
					res_d = '0;
					if (cnt_q == '0) begin
						if (req.opcode == ntm_pkg::OP_QUERY) begin
							res_d.status = ntm_pkg::ST_EMPTY;
						end else begin
							wr_en = 1'b1;
							wr_addr = '0;
							wr_data = '{stamp: req.stamp, tag: req.frame_tag,
								objects: req.object_total};
							cnt_d = CW'(1);
							res_d.status = ntm_pkg::ST_INSERTED;
						end
						state_d = ntm_pkg::S_RESP;
					end else begin
						rd_en = 1'b1;
						rd_addr = '0;
						idx_d = '0;
						state_d = ntm_pkg::S_SCAN;
					end
				end
			end

			ntm_pkg::S_SCAN: begin
				if (op_q == ntm_pkg::OP_INSERT) begin
					if (carrying_q) begin
						// ripple the displaced entry up one slot
						wr_en = 1'b1;
						wr_data = carry_q;
						carry_d = rd_data;
						if (is_last) begin
							state_d = ntm_pkg::S_TAIL;
						end else begin
							rd_en = 1'b1;
							idx_d = idx_q + AW'(1);
						end
					end else if (rd_data.stamp == key_q) begin
						wr_en = 1'b1;
						res_d.status = ntm_pkg::ST_REPLACED;
						state_d = ntm_pkg::S_RESP;
					end else if (rd_data.stamp > key_q) begin
						if (full) begin
							res_d.status = ntm_pkg::ST_DROPPED;
							state_d = ntm_pkg::S_RESP;
						end else begin
							wr_en = 1'b1;
							carry_d = rd_data;
							carrying_d = 1'b1;
							if (is_last) begin
								state_d = ntm_pkg::S_TAIL;
							end else begin
								rd_en = 1'b1;
								idx_d = idx_q + AW'(1);
							end
						end
					end else if (is_last) begin
						if (full) begin
							res_d.status = ntm_pkg::ST_DROPPED;
						end else begin
							wr_en = 1'b1;
							wr_addr = cnt_q[AW-1:0];
							cnt_d = cnt_q + CW'(1);
							res_d.status = ntm_pkg::ST_INSERTED;
						end
						state_d = ntm_pkg::S_RESP;
					end else begin
						rd_en = 1'b1;
						idx_d = idx_q + AW'(1);
					end
				end else begin
					if (rd_data.stamp >= key_q) begin
						res_d.status = ntm_pkg::ST_MATCHED;
						if (idx_q == '0 || d_prev > d_next) begin
							res_d.match_stamp = rd_data.stamp;
							res_d.match_tag = rd_data.tag;
							res_d.match_objects = rd_data.objects;
							res_d.time_error = d_next;
						end else begin
							res_d.match_stamp = prev_q.stamp;
							res_d.match_tag = prev_q.tag;
							res_d.match_objects = prev_q.objects;
							res_d.time_error = d_prev;
						end
						state_d = ntm_pkg::S_RESP;
					end else if (is_last) begin
						res_d.status = ntm_pkg::ST_MATCHED;
						res_d.match_stamp = rd_data.stamp;
						res_d.match_tag = rd_data.tag;
						res_d.match_objects = rd_data.objects;
						res_d.time_error = d_tail;
						state_d = ntm_pkg::S_RESP;
					end else begin
						prev_d = rd_data;
						rd_en = 1'b1;
						idx_d = idx_q + AW'(1);
					end
				end
			end

			ntm_pkg::S_TAIL: begin
				wr_en = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_data = carry_q;
				cnt_d = cnt_q + CW'(1);
				res_d.status = ntm_pkg::ST_INSERTED;
				state_d = ntm_pkg::S_RESP;
			end

			ntm_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ntm_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ntm_pkg::S_IDLE;
			end
		endcase
	end

	`ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "entry count above table depth")
	`ASSERT_IMPLIES(a_scan_idx, state_q == ntm_pkg::S_SCAN, CW'(idx_q) < cnt_q, "scan index past count")
	`ASSERT_IMPLIES(a_tail_room, state_q == ntm_pkg::S_TAIL, !full, "tail write into full table")
	`ASSERT_IMPLIES(a_no_wr_resp, state_q == ntm_pkg::S_RESP, !wr_en && !rd_en, "ram access while responding")
	`ASSERT_NEXT(a_cnt_hold, state_q == ntm_pkg::S_RESP, cnt_q == $past(cnt_q), "count moved while responding")

endmodule

@@ src/nearest_timestamp_matcher.sv @@
// channel | valid     | ready     | payload          | moves
// --------+-----------+-----------+------------------+--------------------------
// request | req_valid | req_ready | req (req_t)      | insert or query
// result  | rsp_valid | rsp_ready | rsp (rsp_t)      | one result per request
//
// A request walks the table RAM one entry per cycle through its single read port;
// an insert ripples the tail of the table up one slot behind the read.
// Reset clears the entry count, the controller state and the result valid flag;
// table contents need no clearing.
// A finished result waits in the output register while the next request is taken.
module nearest_timestamp_matcher #(
	parameter int TABLE_DEPTH = ntm_pkg::DEFAULT_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input ntm_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output ntm_pkg::rsp_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	ntm_pkg::entry_t wr_data, rd_data;
	logic res_valid, res_ready;
	ntm_pkg::rsp_t res;
	logic rsp_valid_q;
	ntm_pkg::rsp_t rsp_q;

	ntm_table_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ntm_ctrl #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ test/nearest_timestamp_matcher_tb.sv @@
`timescale 1ns / 100ps

module nearest_timestamp_matcher_tb;

	localparam int DEPTH = ntm_pkg::DEFAULT_DEPTH;
	localparam int STAMP_W = ntm_pkg::STAMP_W;
	localparam int TAG_W = ntm_pkg::TAG_W;
	localparam int OBJ_W = ntm_pkg::OBJ_W;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ntm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ntm_pkg::rsp_t rsp;

	ntm_pkg::req_t request_queue[$];
	ntm_pkg::rsp_t awaited_results[$];
	bit [STAMP_W-1:0] known_stamps[$];

	bit [STAMP_W-1:0] shadow_stamp[DEPTH];
	bit [TAG_W-1:0] shadow_tag[DEPTH];
	bit [OBJ_W-1:0] shadow_objects[DEPTH];
	int shadow_count = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	nearest_timestamp_matcher #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic ntm_pkg::rsp_t predict_result(ntm_pkg::req_t r);
		ntm_pkg::rsp_t res;
		int pos;
		int pick;
		bit [STAMP_W-1:0] err;
		bit [STAMP_W-1:0] d_next;
		bit [STAMP_W-1:0] d_prev;
		res = '0;
		pos = 0;
		pick = 0;
		err = '0;
		while (pos < shadow_count && shadow_stamp[pos] < r.stamp)
			pos++;
		if (r.opcode == ntm_pkg::OP_INSERT) begin
			if (pos < shadow_count && shadow_stamp[pos] == r.stamp) begin
				shadow_tag[pos] = r.frame_tag;
				shadow_objects[pos] = r.object_total;
				res.status = ntm_pkg::ST_REPLACED;
			end else if (shadow_count >= DEPTH) begin
				res.status = ntm_pkg::ST_DROPPED;
			end else begin
				for (int k = shadow_count; k > pos; k--) begin
					shadow_stamp[k] = shadow_stamp[k-1];
					shadow_tag[k] = shadow_tag[k-1];
					shadow_objects[k] = shadow_objects[k-1];
				end
				shadow_stamp[pos] = r.stamp;
				shadow_tag[pos] = r.frame_tag;
				shadow_objects[pos] = r.object_total;
				shadow_count++;
				res.status = ntm_pkg::ST_INSERTED;
			end
		end else if (shadow_count == 0) begin
			res.status = ntm_pkg::ST_EMPTY;
		end else begin
			if (pos >= shadow_count) begin
				pick = shadow_count - 1;
				err = r.stamp - shadow_stamp[pick];
			end else if (pos == 0) begin
				pick = 0;
				err = shadow_stamp[0] - r.stamp;
			end else begin
				d_next = shadow_stamp[pos] - r.stamp;
				d_prev = r.stamp - shadow_stamp[pos-1];
				if (d_prev <= d_next) begin
					pick = pos - 1;
					err = d_prev;
				end else begin
					pick = pos;
					err = d_next;
				end
			end
			res.status = ntm_pkg::ST_MATCHED;
			res.match_stamp = shadow_stamp[pick];
			res.match_tag = shadow_tag[pick];
			res.match_objects = shadow_objects[pick];
			res.time_error = err;
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		bit fire;
		fire = (req_valid === 1'b1) && (req_ready === 1'b1);
		if (fire)
			awaited_results.push_back(predict_result(req));
		if (fire || req_valid !== 1'b1) begin
			if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req <= request_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		ntm_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.match_stamp !== want.match_stamp) begin
					$display("%0t: match_stamp expected %h actual %h",
						$time, want.match_stamp, rsp.match_stamp);
					mismatch_count++;
				end
				if (rsp.match_tag !== want.match_tag) begin
					$display("%0t: match_tag expected %h actual %h",
						$time, want.match_tag, rsp.match_tag);
					mismatch_count++;
				end
				if (rsp.match_objects !== want.match_objects) begin
					$display("%0t: match_objects expected %h actual %h",
						$time, want.match_objects, rsp.match_objects);
					mismatch_count++;
				end
				if (rsp.time_error !== want.time_error) begin
					$display("%0t: time_error expected %h actual %h",
						$time, want.time_error, rsp.time_error);
					mismatch_count++;
				end
			end
		end
		rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid === 1'b1 && req_ready === 1'b1) ||
				(rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress", $time);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic bit [STAMP_W-1:0] rand_stamp();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		return wide[STAMP_W-1:0];
	endfunction

	function automatic bit [STAMP_W-1:0] pick_known();
		return known_stamps[$urandom_range(0, known_stamps.size() - 1)];
	endfunction

	task automatic queue_request(logic op, bit [STAMP_W-1:0] s, bit [TAG_W-1:0] tag,
		bit [OBJ_W-1:0] objs);
		ntm_pkg::req_t r;
		bit found;
		r.opcode = op;
		r.stamp = s;
		r.frame_tag = tag;
		r.object_total = objs;
		request_queue.push_back(r);
		found = 1'b0;
		if (op == ntm_pkg::OP_INSERT) begin
			foreach (known_stamps[i])
				if (known_stamps[i] == s)
					found = 1'b1;
			if (!found && known_stamps.size() < DEPTH)
				known_stamps.push_back(s);
		end
	endtask

	task automatic queue_random(int unsigned insert_pct, int unsigned new_pct);
		bit [STAMP_W-1:0] s;
		bit [STAMP_W:0] sum;
		if ($urandom_range(0, 99) < insert_pct) begin
			if (known_stamps.size() != 0 && $urandom_range(0, 99) >= new_pct) begin
				s = pick_known();
			end else begin
				case ($urandom_range(0, 2))
					0: s = rand_stamp();
					1: s = STAMP_W'($urandom_range(0, 5000));
					default: begin
						if (known_stamps.size() != 0)
							s = pick_known() + STAMP_W'($urandom_range(1, 300));
						else
							s = rand_stamp();
					end
				endcase
			end
			queue_request(ntm_pkg::OP_INSERT, s, TAG_W'($urandom_range(0, 65535)),
				OBJ_W'($urandom_range(0, 65535)));
		end else begin
			if (known_stamps.size() == 0) begin
				s = rand_stamp();
			end else begin
				case ($urandom_range(0, 5))
					0: s = rand_stamp();
					1: s = pick_known();
					2: begin
						sum = (STAMP_W+1)'(pick_known()) + (STAMP_W+1)'(pick_known());
						s = sum[STAMP_W:1];
					end
					3: s = pick_known() + STAMP_W'($urandom_range(0, 3));
					4: s = pick_known() - STAMP_W'($urandom_range(0, 3));
					default: s = $urandom_range(0, 1) ? '0 : '1;
				endcase
			end
			queue_request(ntm_pkg::OP_QUERY, s, TAG_W'($urandom_range(0, 65535)),
				OBJ_W'($urandom_range(0, 65535)));
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || req_valid === 1'b1 || awaited_results.size() != 0);
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int items,
		int unsigned insert_pct, int unsigned new_pct, bit with_hold);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (with_hold)
			hold_arm = 1'b1;
		repeat (items)
			queue_random(insert_pct, new_pct);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// empty table, then single entry edges, ties, replace, extremes
		queue_request(ntm_pkg::OP_QUERY, '0, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, '1, 16'hFFFF, 16'hFFFF);
		queue_request(ntm_pkg::OP_INSERT, 48'd1000, 16'hFFFF, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, '0, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, '1, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_INSERT, 48'd2000, 16'h0000, 16'hFFFF);
		queue_request(ntm_pkg::OP_QUERY, 48'd1500, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, 48'd1501, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, 48'd1499, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, 48'd2000, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_INSERT, 48'd2000, 16'h1234, 16'h5678);
		queue_request(ntm_pkg::OP_QUERY, 48'd2100, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_INSERT, '1, 16'hFFFF, 16'hFFFF);
		queue_request(ntm_pkg::OP_QUERY, '1, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, 48'h8000_0000_0000, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_INSERT, '0, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, '0, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_QUERY, 48'd500, 16'h0000, 16'h0000);
		queue_request(ntm_pkg::OP_INSERT, 48'd1500, 16'hA5A5, 16'h5A5A);
		queue_request(ntm_pkg::OP_INSERT, 48'd1000, 16'h0F0F, 16'hF0F0);
		queue_request(ntm_pkg::OP_QUERY, 48'd1250, 16'h0000, 16'h0000);
		drain();

		run_phase(0, 0, 110, 30, 40, 1'b0);
		run_phase(83, 0, 110, 30, 40, 1'b0);
		run_phase(0, 83, 110, 30, 40, 1'b0);
		// table fills and overflows here, receiver held off at the start
		run_phase(26, 26, 120, 70, 70, 1'b1);

		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
